>>> src/rsst_pkg.sv
// ============================================================================
// rsst_pkg: shared types and constants for the record sorter
// Record layout, channel transaction structs, controller states and the
// command and status bundles between controller and datapath.
// ============================================================================
package rsst_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int IDX_W       = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int ID_W    = 32;
  localparam int PRICE_W = 24;
  localparam int QTY_W   = 16;
  localparam int SALE_W  = 40;
  localparam int TOTAL_W = 47;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic signed [ID_W-1:0] product_id;
    logic [PRICE_W-1:0]     unit_price_cents;
    logic [QTY_W-1:0]       quantity;
    logic                   last_record;
  } in_item_t;

  typedef struct packed {
    logic signed [ID_W-1:0] sorted_id;
    logic [PRICE_W-1:0]     sorted_price_cents;
    logic [QTY_W-1:0]       sorted_quantity;
    logic [SALE_W-1:0]      sale_cents;
    logic [TOTAL_W-1:0]     running_total_cents;
    logic                   last_result;
  } out_item_t;

  // One stored record as it sits in the record memory.
  typedef struct packed {
    logic signed [ID_W-1:0] id;
    logic [PRICE_W-1:0]     price;
    logic [QTY_W-1:0]       qty;
  } rec_t;

  typedef enum logic [1:0] {
    WR_INPUT,
    WR_RDATA,
    WR_CARRY
  } wr_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS_RD0,
    S_PASS_CARRY,
    S_PASS_STEP,
    S_PASS_END,
    S_EMIT_RD,
    S_EMIT_MUL,
    S_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic             wr_en;
    wr_src_t          wr_src;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             carry_load;
    logic             prod_load;
    logic             clr_total;
    logic             out_load;
    logic             out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic key_gt;
    logic out_busy;
  } dp_status_t;

endpackage

>>> src/rsst_datapath.sv
// ============================================================================
// rsst_datapath: record memory, sort carry, multiplier and output register
// Holds the records, performs the compare-and-carry step of a bubble pass,
// forms each sale and the saturating total, and drives the result channel.
// ============================================================================
module rsst_datapath
  import rsst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  logic       out_stall,
  output logic       out_valid,
  output out_item_t  out_data
);

  rec_t               mem_r [MAX_RECORDS];
  rec_t               rd_data_r;
  rec_t               carry_r;
  rec_t               rec_r;
  rec_t               wr_data;
  logic [SALE_W-1:0]  sale_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic [TOTAL_W:0]   total_sum;
  logic               out_valid_r;
  out_item_t          out_data_r;

  always_comb begin
    case (cmd.wr_src)
      WR_INPUT: wr_data = '{id:    in_data.product_id,
                            price: in_data.unit_price_cents,
                            qty:   in_data.quantity};
      WR_RDATA: wr_data = rd_data_r;
      WR_CARRY: wr_data = carry_r;
      default:  wr_data = carry_r;
    endcase
  end

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[cmd.wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[cmd.rd_addr];
  end

  assign status.key_gt   = carry_r.id > rd_data_r.id;
  assign status.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.carry_load) begin
      carry_r <= rd_data_r;
    end
    if (cmd.prod_load) begin
      rec_r  <= rd_data_r;
      sale_r <= SALE_W'(rd_data_r.price) * SALE_W'(rd_data_r.qty);
    end
  end

  assign total_sum = (TOTAL_W+1)'(total_r) + (TOTAL_W+1)'(sale_r);
  assign total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_total) begin
        total_r <= '0;
      end else if (cmd.out_load) begin
        total_r <= total_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.sorted_id           <= rec_r.id;
      out_data_r.sorted_price_cents  <= rec_r.price;
      out_data_r.sorted_quantity     <= rec_r.qty;
      out_data_r.sale_cents          <= sale_r;
      out_data_r.running_total_cents <= total_nxt;
      out_data_r.last_result         <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/rsst_ctrl.sv
// ============================================================================
// rsst_ctrl: sequencer for loading, bubble passes and emission
// Counts stored records, walks each bubble pass over the memory, repeats
// passes until one makes no swap, then reads the records out in order.
// ============================================================================
module rsst_ctrl
  import rsst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             swap_r, swap_nxt;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] idx_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      swap_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      swap_r  <= swap_nxt;
    end
  end

  assign count_m1 = count_r - 1'b1;
  assign idx_ext  = CNT_W'(idx_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    swap_nxt  = swap_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // A record that arrives with the store full is dropped.
          if (count_r < CNT_W'(MAX_RECORDS)) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = WR_INPUT;
            cmd.wr_addr = count_r[IDX_W-1:0];
            count_nxt   = count_r + 1'b1;
          end
          if (in_last) begin
            cmd.clr_total = 1'b1;
            idx_nxt       = '0;
            state_nxt     = (count_nxt >= CNT_W'(2)) ? S_PASS_RD0 : S_EMIT_RD;
          end
        end
      end

      S_PASS_RD0: begin
        cmd.rd_addr = '0;
        swap_nxt    = 1'b0;
        state_nxt   = S_PASS_CARRY;
      end

      S_PASS_CARRY: begin
        cmd.carry_load = 1'b1;
        cmd.rd_addr    = IDX_W'(1);
        idx_nxt        = IDX_W'(1);
        state_nxt      = S_PASS_STEP;
      end

      S_PASS_STEP: begin
        // The larger of carry and the fresh record moves on; the other lands
        // one slot down.
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = idx_r - 1'b1;
        if (status.key_gt) begin
          cmd.wr_src = WR_RDATA;
          swap_nxt   = 1'b1;
        end else begin
          cmd.wr_src     = WR_CARRY;
          cmd.carry_load = 1'b1;
        end
        if (idx_ext == count_m1) begin
          state_nxt = S_PASS_END;
        end else begin
          cmd.rd_addr = idx_r + 1'b1;
          idx_nxt     = idx_r + 1'b1;
        end
      end

      S_PASS_END: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_CARRY;
        cmd.wr_addr = count_m1[IDX_W-1:0];
        if (swap_r) begin
          state_nxt = S_PASS_RD0;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_EMIT_RD;
        end
      end

      S_EMIT_RD: begin
        cmd.rd_addr = idx_r;
        state_nxt   = S_EMIT_MUL;
      end

      S_EMIT_MUL: begin
        cmd.prod_load = 1'b1;
        state_nxt     = S_EMIT_OUT;
      end

      S_EMIT_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (idx_ext == count_m1);
          if (idx_ext == count_m1) begin
            count_nxt = '0;
            swap_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/record_sort_sales_total.sv
// ============================================================================
// record_sort_sales_total: product record sorter with running sales total
// Loads records until one is marked last, bubble-sorts them by signed ID
// with a stable compare, then emits each record with its sale and total.
// ============================================================================
//
//   Channel | Ports                           | Payload
//   --------+---------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data     | in_item_t: id, price, quantity
//   result  | out_valid, out_stall, out_data  | out_item_t: record, sale, total
//
// A record transaction is taken while the block is idle. After the record
// marked last, the input is stalled while the block sorts and emits. Each
// bubble pass over N records runs through the record memory, which has one
// read and one write port, and up to N passes are made. Emission then steps
// through a memory read, a multiply, and the total and output register for
// each record, and waits while the result channel is stalled. The last
// result is loaded into the output register as the block returns to idle,
// so the next set can start loading while that transaction still waits.
// Reset is synchronous and active low; the record memory itself is not
// cleared, since only entries written in the current set are ever read.
//
// Each bubble pass keeps the larger record in a carry register and writes the
// smaller one back, so a pass needs only one read and one write per cycle.
// Equal IDs never swap, which keeps records with equal IDs in arrival order.
// The sale is the exact 40-bit product of price and quantity, and the total
// saturates at its 47-bit maximum.
//
module record_sort_sales_total
  import rsst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,

  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,

  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The sequencer decides every memory access and register load.
  rsst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_record),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the records and produces the result transactions.
  rsst_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> src/rsst_checker.sv
// ============================================================================
// rsst_checker: port-level checks for the record sorter
// Watches the top-level channels and flags handshake or sequencing slips.
// ============================================================================
module rsst_checker
  import rsst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A result held by a stall stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction withdrawn while stalled");

  // A stalled result does not change.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Taking the last record of a set must close the input for sorting.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_record |=> in_stall)
    else $error("input still open after the last record");

  // Results are only produced while the input is closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was loading");

  // The total includes the current sale.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.running_total_cents >= TOTAL_W'(out_data.sale_cents)))
    else $error("running total below the current sale");

endmodule

bind record_sort_sales_total rsst_checker u_rsst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
